// ----- hdl/terq_pkg.sv -----
// ----------------------------------------------------------------------------
// Timed event release queue package
// Shared request codes, controller states, datapath commands and entry format.
// ----------------------------------------------------------------------------
package terq_pkg;

	localparam int SCORE_DEPTH_DEF   = 16;
	localparam int GENERAL_DEPTH_DEF = 16;

	localparam int REQ_W  = 3;
	localparam int ID_W   = 16;
	localparam int TYPE_W = 8;
	localparam int TIME_W = 32;

	typedef enum logic [REQ_W-1:0] {
		REQ_INIT    = 3'd0,
		REQ_SCORE   = 3'd1,
		REQ_GENERAL = 3'd2,
		REQ_EXEC    = 3'd3,
		REQ_TICK    = 3'd4,
		REQ_CLEAR   = 3'd5
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SIMPLE,
		ST_TICK,
		ST_SCORE,
		ST_GEN,
		ST_FLUSH
	} state_t;

	typedef enum logic [2:0] {
		DP_NONE,
		DP_SIMPLE,
		DP_TICK,
		DP_SCORE,
		DP_GEN,
		DP_FLUSH
	} dp_op_t;

	typedef struct packed {
		logic   capture;
		dp_op_t op;
	} cmd_t;

	typedef struct packed {
		logic score_done;
		logic gen_done;
	} status_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TYPE_W-1:0] kind;
		logic [TIME_W-1:0] due;
	} entry_t;

	localparam logic OUTCOME_RELEASED = 1'b0;
	localparam logic OUTCOME_DROPPED  = 1'b1;

endpackage

// ----- hdl/timed_event_release_queue.sv -----
// ----------------------------------------------------------------------------
// Timed event release queue
// Score and general pending-event lists with due-time release on tick.
// ----------------------------------------------------------------------------
// Non-tick requests give at most one result, registered after the single-step
// state. A tick releases due score heads, then scans every general entry, one
// entry per cycle through the read port of each list; busy covers the scan.
// One request at a time; results are one-cycle strobes the receiver must take.
// Reset clears counts and the deferred clear; list storage is not cleared.
// ----------------------------------------------------------------------------
module timed_event_release_queue #(
	parameter int SCORE_DEPTH   = terq_pkg::SCORE_DEPTH_DEF,
	parameter int GENERAL_DEPTH = terq_pkg::GENERAL_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [terq_pkg::REQ_W-1:0]    req_type,
	input  logic [terq_pkg::ID_W-1:0]     event_id,
	input  logic [terq_pkg::TYPE_W-1:0]   event_type,
	input  logic [terq_pkg::TIME_W-1:0]   event_time,
	input  logic [terq_pkg::TIME_W-1:0]   now_time,
	output logic                          result_valid,
	output logic [terq_pkg::ID_W-1:0]     out_event_id,
	output logic [terq_pkg::TYPE_W-1:0]   out_event_type,
	output logic                          outcome,
	output logic                          last
);

	terq_pkg::cmd_t    cmd;
	terq_pkg::status_t status;

	terq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.status   (status),
		.cmd      (cmd),
		.busy     (busy)
	);

	terq_dp #(
		.SCORE_DEPTH   (SCORE_DEPTH),
		.GENERAL_DEPTH (GENERAL_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.req_type       (req_type),
		.event_id       (event_id),
		.event_type     (event_type),
		.event_time     (event_time),
		.now_time       (now_time),
		.result_valid   (result_valid),
		.out_event_id   (out_event_id),
		.out_event_type (out_event_type),
		.outcome        (outcome),
		.last           (last)
	);

endmodule

// ----- hdl/terq_ctrl.sv -----
// ----------------------------------------------------------------------------
// Timed event release queue controller
// Sequences one request at a time: single-step requests, or the tick scan.
// ----------------------------------------------------------------------------
module terq_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [terq_pkg::REQ_W-1:0]    req_type,
	input  terq_pkg::status_t             status,
	output terq_pkg::cmd_t                cmd,
	output logic                          busy
);

	terq_pkg::state_t state_q;
	terq_pkg::state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= terq_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx    = state_q;
		cmd.capture = 1'b0;
		cmd.op      = terq_pkg::DP_NONE;
		busy        = 1'b1;
		case (state_q)
			terq_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.capture = 1'b1;
					if (req_type == terq_pkg::REQ_TICK) begin
						state_nx = terq_pkg::ST_TICK;
					end else begin
						state_nx = terq_pkg::ST_SIMPLE;
					end
				end
			end
			terq_pkg::ST_SIMPLE: begin
				cmd.op   = terq_pkg::DP_SIMPLE;
				state_nx = terq_pkg::ST_IDLE;
			end
			terq_pkg::ST_TICK: begin
				cmd.op   = terq_pkg::DP_TICK;
				state_nx = terq_pkg::ST_SCORE;
			end
			terq_pkg::ST_SCORE: begin
				cmd.op = terq_pkg::DP_SCORE;
				if (status.score_done) begin
					state_nx = terq_pkg::ST_GEN;
				end
			end
			terq_pkg::ST_GEN: begin
				cmd.op = terq_pkg::DP_GEN;
				if (status.gen_done) begin
					state_nx = terq_pkg::ST_FLUSH;
				end
			end
			terq_pkg::ST_FLUSH: begin
				cmd.op   = terq_pkg::DP_FLUSH;
				state_nx = terq_pkg::ST_IDLE;
			end
			default: begin
				state_nx = terq_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ----- hdl/terq_dp.sv -----
// ----------------------------------------------------------------------------
// Timed event release queue datapath
// Score ring buffer, general list with in-place compaction, result staging.
// ----------------------------------------------------------------------------
module terq_dp #(
	parameter int SCORE_DEPTH   = terq_pkg::SCORE_DEPTH_DEF,
	parameter int GENERAL_DEPTH = terq_pkg::GENERAL_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  terq_pkg::cmd_t                cmd,
	output terq_pkg::status_t             status,
	input  logic [terq_pkg::REQ_W-1:0]    req_type,
	input  logic [terq_pkg::ID_W-1:0]     event_id,
	input  logic [terq_pkg::TYPE_W-1:0]   event_type,
	input  logic [terq_pkg::TIME_W-1:0]   event_time,
	input  logic [terq_pkg::TIME_W-1:0]   now_time,
	output logic                          result_valid,
	output logic [terq_pkg::ID_W-1:0]     out_event_id,
	output logic [terq_pkg::TYPE_W-1:0]   out_event_type,
	output logic                          outcome,
	output logic                          last
);

	localparam int SIW = (SCORE_DEPTH > 1) ? $clog2(SCORE_DEPTH) : 1;
	localparam int SCW = $clog2(SCORE_DEPTH + 1);
	localparam int STW = SIW + 2;
	localparam int GIW = (GENERAL_DEPTH > 1) ? $clog2(GENERAL_DEPTH) : 1;
	localparam int GCW = $clog2(GENERAL_DEPTH + 1);
	localparam int GNW = GCW + 1;

	// captured request
	logic [terq_pkg::REQ_W-1:0]  req_q;
	terq_pkg::entry_t            new_q;
	logic [terq_pkg::TIME_W-1:0] now_q;

	// list storage
	terq_pkg::entry_t score_mem [SCORE_DEPTH];
	terq_pkg::entry_t gen_mem   [GENERAL_DEPTH];
	terq_pkg::entry_t sc_rd_q;
	terq_pkg::entry_t gen_rd_q;

	logic [SIW-1:0] sc_head_q;
	logic [SCW-1:0] sc_cnt_q;
	logic [GCW-1:0] gen_cnt_q;
	logic [GCW-1:0] gen_i_q;
	logic [GCW-1:0] gen_k_q;
	logic           clear_q;

	// staged result, held until the next one shows whether it is the last
	logic                          held_v_q;
	logic [terq_pkg::ID_W-1:0]     held_id_q;
	logic [terq_pkg::TYPE_W-1:0]   held_type_q;

	logic                          out_valid_q;
	logic [terq_pkg::ID_W-1:0]     out_id_q;
	logic [terq_pkg::TYPE_W-1:0]   out_type_q;
	logic                          outcome_q;
	logic                          last_q;

	// address arithmetic
	logic [SIW:0]   sc_head_sum;
	logic [SIW-1:0] sc_head_inc;
	logic [STW-1:0] sc_tail_sum;
	logic [SIW-1:0] sc_tail;
	logic [GNW-1:0] gen_next_sum;
	logic [GIW-1:0] gen_next_addr;

	logic sc_full;
	logic gen_full;
	logic new_due;
	logic sc_due;
	logic gen_due;
	logic gen_active;
	logic sc_release;
	logic gen_release;

	// simple request decode
	logic                        simple_push;
	logic                        simple_outcome;
	logic                        sc_append;
	logic                        gen_append;
	logic                        set_clear;

	logic                        sc_re;
	logic [SIW-1:0]              sc_rd_addr;
	logic                        gen_re;
	logic [GIW-1:0]              gen_rd_addr;
	logic                        gen_we;
	logic [GIW-1:0]              gen_wr_addr;
	terq_pkg::entry_t            gen_wr_data;

	logic                        tick_push;
	logic [terq_pkg::ID_W-1:0]   tick_id;
	logic [terq_pkg::TYPE_W-1:0] tick_type;

	assign sc_head_sum = {1'b0, sc_head_q} + (SIW+1)'(1);
	assign sc_head_inc = (sc_head_sum >= (SIW+1)'(SCORE_DEPTH)) ? '0 : sc_head_sum[SIW-1:0];
	assign sc_tail_sum = STW'(sc_head_q) + STW'(sc_cnt_q);
	always_comb begin
		if (sc_tail_sum >= STW'(SCORE_DEPTH)) begin
			sc_tail = SIW'(sc_tail_sum - STW'(SCORE_DEPTH));
		end else begin
			sc_tail = sc_tail_sum[SIW-1:0];
		end
	end

	assign gen_next_sum  = GNW'(gen_i_q) + GNW'(1);
	assign gen_next_addr = (gen_next_sum >= GNW'(GENERAL_DEPTH)) ? '0
		: gen_next_sum[GIW-1:0];

	assign sc_full    = (sc_cnt_q == SCW'(SCORE_DEPTH));
	assign gen_full   = (gen_cnt_q == GCW'(GENERAL_DEPTH));
	assign new_due    = (new_q.due <= now_q);
	assign sc_due     = (sc_rd_q.due <= now_q);
	assign gen_due    = (gen_rd_q.due <= now_q);
	assign gen_active = (gen_i_q != gen_cnt_q);

	assign sc_release  = (cmd.op == terq_pkg::DP_SCORE) && (sc_cnt_q != '0) && sc_due;
	assign gen_release = (cmd.op == terq_pkg::DP_GEN) && gen_active && gen_due;

	assign status.score_done = (sc_cnt_q == '0) || !sc_due;
	assign status.gen_done   = !gen_active;

	always_comb begin
		simple_push    = 1'b0;
		simple_outcome = terq_pkg::OUTCOME_RELEASED;
		sc_append      = 1'b0;
		gen_append     = 1'b0;
		set_clear      = 1'b0;
		if (cmd.op == terq_pkg::DP_SIMPLE) begin
			case (req_q)
				terq_pkg::REQ_INIT: begin
					if (new_q.kind != '0) begin
						if (sc_full) begin
							simple_push    = 1'b1;
							simple_outcome = terq_pkg::OUTCOME_DROPPED;
						end else begin
							sc_append = 1'b1;
						end
					end
				end
				terq_pkg::REQ_SCORE: begin
					if (new_q.kind != '0) begin
						if (new_due) begin
							simple_push = 1'b1;
						end else if (sc_full) begin
							simple_push    = 1'b1;
							simple_outcome = terq_pkg::OUTCOME_DROPPED;
						end else begin
							sc_append = 1'b1;
						end
					end
				end
				terq_pkg::REQ_GENERAL: begin
					if (new_q.kind != '0) begin
						if (new_due) begin
							simple_push = 1'b1;
						end else if (gen_full) begin
							simple_push    = 1'b1;
							simple_outcome = terq_pkg::OUTCOME_DROPPED;
						end else begin
							gen_append = 1'b1;
						end
					end
				end
				terq_pkg::REQ_EXEC: begin
					simple_push = 1'b1;
				end
				terq_pkg::REQ_CLEAR: begin
					set_clear = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// read ports: the head is reread after every release, the general list streams
	always_comb begin
		sc_re       = 1'b0;
		sc_rd_addr  = sc_head_q;
		gen_re      = 1'b0;
		gen_rd_addr = '0;
		case (cmd.op)
			terq_pkg::DP_TICK: begin
				sc_re  = 1'b1;
				gen_re = 1'b1;
			end
			terq_pkg::DP_SCORE: begin
				sc_re      = 1'b1;
				sc_rd_addr = sc_release ? sc_head_inc : sc_head_q;
			end
			terq_pkg::DP_GEN: begin
				gen_re      = 1'b1;
				gen_rd_addr = gen_next_addr;
			end
			default: begin
			end
		endcase
	end

	// keep a surviving general entry by writing it back at the compacted slot
	always_comb begin
		gen_we      = gen_append;
		gen_wr_addr = gen_cnt_q[GIW-1:0];
		gen_wr_data = new_q;
		if ((cmd.op == terq_pkg::DP_GEN) && gen_active && !gen_due) begin
			gen_we      = 1'b1;
			gen_wr_addr = gen_k_q[GIW-1:0];
			gen_wr_data = gen_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (sc_append) begin
			score_mem[sc_tail] <= new_q;
		end
		if (sc_re) begin
			sc_rd_q <= score_mem[sc_rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (gen_we) begin
			gen_mem[gen_wr_addr] <= gen_wr_data;
		end
		if (gen_re) begin
			gen_rd_q <= gen_mem[gen_rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q        <= req_type;
			new_q.id     <= event_id;
			new_q.kind   <= event_type;
			new_q.due    <= event_time;
			now_q        <= now_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_head_q <= '0;
			sc_cnt_q  <= '0;
			gen_cnt_q <= '0;
			gen_i_q   <= '0;
			gen_k_q   <= '0;
			clear_q   <= 1'b0;
		end else begin
			if (sc_append) begin
				sc_cnt_q <= sc_cnt_q + SCW'(1);
			end
			if (gen_append) begin
				gen_cnt_q <= gen_cnt_q + GCW'(1);
			end
			if (set_clear) begin
				clear_q <= 1'b1;
			end
			if (cmd.op == terq_pkg::DP_TICK) begin
				gen_i_q <= '0;
				gen_k_q <= '0;
				if (clear_q) begin
					sc_cnt_q  <= '0;
					gen_cnt_q <= '0;
					clear_q   <= 1'b0;
				end
			end
			if (sc_release) begin
				sc_head_q <= sc_head_inc;
				sc_cnt_q  <= sc_cnt_q - SCW'(1);
			end
			if (cmd.op == terq_pkg::DP_GEN) begin
				if (gen_active) begin
					gen_i_q <= gen_i_q + GCW'(1);
					if (!gen_due) begin
						gen_k_q <= gen_k_q + GCW'(1);
					end
				end else begin
					gen_cnt_q <= gen_k_q;
				end
			end
		end
	end

	assign tick_push = sc_release || gen_release;
	assign tick_id   = sc_release ? sc_rd_q.id : gen_rd_q.id;
	assign tick_type = sc_release ? sc_rd_q.kind : gen_rd_q.kind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= simple_push || (tick_push && held_v_q)
				|| ((cmd.op == terq_pkg::DP_FLUSH) && held_v_q);
			if (tick_push) begin
				held_v_q <= 1'b1;
			end else if (cmd.op == terq_pkg::DP_FLUSH) begin
				held_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (simple_push) begin
			out_id_q   <= new_q.id;
			out_type_q <= new_q.kind;
			outcome_q  <= simple_outcome;
			last_q     <= 1'b1;
		end else if (tick_push || (cmd.op == terq_pkg::DP_FLUSH)) begin
			out_id_q   <= held_id_q;
			out_type_q <= held_type_q;
			outcome_q  <= terq_pkg::OUTCOME_RELEASED;
			last_q     <= (cmd.op == terq_pkg::DP_FLUSH);
		end
		if (tick_push) begin
			held_id_q   <= tick_id;
			held_type_q <= tick_type;
		end
	end

	assign result_valid   = out_valid_q;
	assign out_event_id   = out_id_q;
	assign out_event_type = out_type_q;
	assign outcome        = outcome_q;
	assign last           = last_q;

	a_score_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sc_cnt_q <= SCW'(SCORE_DEPTH))
		else $error("score count above depth");

	a_compact_behind_scan: assert property (@(posedge clk) disable iff (!arst_n)
		gen_k_q <= gen_i_q)
		else $error("general write slot ahead of scan");

	a_flush_empties_stage: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == terq_pkg::DP_FLUSH |=> !held_v_q)
		else $error("staged result left after flush");

	a_simple_stage_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == terq_pkg::DP_SIMPLE |-> !held_v_q)
		else $error("staged result pending at single-step request");

endmodule
